// ===== hdl/g4oled_pkg.sv =====
// Shared types, constants and the controller start-up table for the grayscale OLED writer.
// Used by every module under hdl except g4oled_ram; it has no dependencies of its own.
package g4oled_pkg;

  // Panel geometry and the packed shadow frame (two pixels per byte).
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 96;
  localparam int ROW_BYTES    = (PANEL_WIDTH + 1) / 2;
  localparam int FRAME_BYTES  = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_BYTES);
  localparam int CMP_W        = 9;

  // Input function codes.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_INIT  = 1'b1;

  // Controller command bytes.
  localparam logic [7:0] CMD_SET_COL = 8'h15;
  localparam logic [7:0] CMD_SET_ROW = 8'h75;
  localparam logic [7:0] CMD_NOP     = 8'he3;

  // Byte sequencer.
  localparam int INIT_BYTES  = 62;
  localparam int PIXEL_BYTES = 7;
  localparam int STEP_W      = $clog2(INIT_BYTES);

  localparam logic [STEP_W-1:0] PX_COL_CMD  = STEP_W'(0);
  localparam logic [STEP_W-1:0] PX_COL_LO   = STEP_W'(1);
  localparam logic [STEP_W-1:0] PX_COL_HI   = STEP_W'(2);
  localparam logic [STEP_W-1:0] PX_ROW_CMD  = STEP_W'(3);
  localparam logic [STEP_W-1:0] PX_ROW_LO   = STEP_W'(4);
  localparam logic [STEP_W-1:0] PX_ROW_HI   = STEP_W'(5);
  localparam logic [STEP_W-1:0] PX_DATA     = STEP_W'(6);

  // Command queue between the front end and the byte sequencer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FS_CLEAR,
    FS_RUN
  } front_state_t;

  // One queued job: a whole start-up sequence or one pixel update.
  typedef struct packed {
    logic       is_init;
    logic [5:0] col;
    logic [6:0] row;
    logic [7:0] pix_byte;
  } cmd_desc_t;

  // Start-up command table. Every burst ends in a NOP byte, and NOP appears nowhere else.
  function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      6'd0:  b = 8'hfd;  6'd1:  b = 8'h12;  6'd2:  b = 8'he3;
      6'd3:  b = 8'hae;  6'd4:  b = 8'he3;
      6'd5:  b = 8'h94;  6'd6:  b = 8'h00;  6'd7:  b = 8'he3;
      6'd8:  b = 8'ha8;  6'd9:  b = 8'd95;  6'd10: b = 8'he3;
      6'd11: b = 8'h81;  6'd12: b = 8'hb7;  6'd13: b = 8'he3;
      6'd14: b = 8'h82;  6'd15: b = 8'h3f;  6'd16: b = 8'he3;
      6'd17: b = 8'ha0;  6'd18: b = 8'h52;  6'd19: b = 8'he3;
      6'd20: b = 8'ha1;  6'd21: b = 8'h00;  6'd22: b = 8'he3;
      6'd23: b = 8'ha2;  6'd24: b = 8'h00;  6'd25: b = 8'he3;
      6'd26: b = 8'ha4;  6'd27: b = 8'he3;
      6'd28: b = 8'hb1;  6'd29: b = 8'h11;  6'd30: b = 8'he3;
      6'd31: b = 8'hb2;  6'd32: b = 8'h23;  6'd33: b = 8'he3;
      6'd34: b = 8'hb3;  6'd35: b = 8'he2;  6'd36: b = 8'he3;
      6'd37: b = 8'hb8;  6'd38: b = 8'd1;   6'd39: b = 8'd2;
      6'd40: b = 8'd3;   6'd41: b = 8'd4;   6'd42: b = 8'd5;
      6'd43: b = 8'd6;   6'd44: b = 8'd8;   6'd45: b = 8'd10;
      6'd46: b = 8'd12;  6'd47: b = 8'd14;  6'd48: b = 8'd16;
      6'd49: b = 8'd19;  6'd50: b = 8'd22;  6'd51: b = 8'd26;
      6'd52: b = 8'd30;  6'd53: b = 8'he3;
      6'd54: b = 8'hbb;  6'd55: b = 8'h01;  6'd56: b = 8'he3;
      6'd57: b = 8'hbc;  6'd58: b = 8'h3f;  6'd59: b = 8'he3;
      6'd60: b = 8'haf;  6'd61: b = 8'he3;
      default: b = CMD_NOP;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/g4oled_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the packed shadow frame.
module g4oled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/g4oled_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Depends on g4oled_pkg for the job descriptor and the queue depth.
module g4oled_queue import g4oled_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_desc_t push_desc,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output cmd_desc_t head_desc
);

  cmd_desc_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    full       = (count_r == QCNT_W'(QUEUE_DEPTH));
    head_valid = (count_r != '0);
    head_desc  = slot_r[rd_ptr_r];
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== hdl/g4oled_front.sv =====
// Front end: accepts input transactions, clears and updates the shadow frame, queues jobs.
// Depends on g4oled_pkg and g4oled_ram.
module g4oled_front import g4oled_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [6:0] in_x,
  input  logic [6:0] in_y,
  input  logic [3:0] in_gray,
  output logic       q_push,
  output cmd_desc_t  q_desc,
  input  logic       q_full
);

  localparam logic [ADDR_W-1:0] ROW_BYTES_A  = ADDR_W'(ROW_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(FRAME_BYTES - 1);

  front_state_t      state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_init_r;
  logic              s1_odd_r;
  logic [3:0]        s1_gray_r;
  logic [5:0]        s1_col_r;
  logic [6:0]        s1_row_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              fwd_hit_r, fwd_hit_nxt;
  logic [7:0]        fwd_data_r;

  logic              accept;
  logic              on_panel;
  logic              clr_we;
  logic              s1_write;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        ram_rdata;
  logic [7:0]        base;
  logic [7:0]        pix_byte;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  // Next state: the clearing pass runs once after reset.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_CLEAR: if (clr_addr_r == LAST_ADDR) state_nxt = FS_RUN;
      FS_RUN:   state_nxt = FS_RUN;
      default:  state_nxt = FS_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    unique case (state_r)
      FS_CLEAR: begin
        clr_we   = 1'b1;
        in_stall = 1'b1;
      end
      FS_RUN: begin
        clr_we   = 1'b0;
        in_stall = s1_valid_r && q_full;
      end
      default: begin
        clr_we   = 1'b0;
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    accept       = in_valid && !in_stall;
    on_panel     = (CMP_W'(in_x) < CMP_W'(PANEL_WIDTH)) && (CMP_W'(in_y) < CMP_W'(PANEL_HEIGHT));
    rd_addr      = ADDR_W'(ADDR_W'(in_y) * ROW_BYTES_A) + ADDR_W'(in_x[6:1]);
    clr_addr_nxt = clr_we ? clr_addr_r + ADDR_W'(1) : clr_addr_r;

    q_push   = s1_valid_r && !q_full;
    s1_write = q_push && !s1_init_r;

    // The item ahead may have written this byte at the edge that took our read.
    base     = fwd_hit_r ? fwd_data_r : ram_rdata;
    pix_byte = s1_odd_r ? {base[7:4], s1_gray_r} : {s1_gray_r, base[3:0]};

    q_desc.is_init  = s1_init_r;
    q_desc.col      = s1_col_r;
    q_desc.row      = s1_row_r;
    q_desc.pix_byte = pix_byte;

    // Off-panel pixels are taken and dropped.
    if (accept) begin
      s1_valid_nxt = (in_func == FUNC_INIT) || on_panel;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    fwd_hit_nxt = accept ? (s1_write && (s1_addr_r == rd_addr)) : fwd_hit_r;

    ram_we    = clr_we || s1_write;
    ram_waddr = clr_we ? clr_addr_r : s1_addr_r;
    ram_wdata = clr_we ? 8'h00 : pix_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FS_CLEAR;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_valid_r <= s1_valid_nxt;
      fwd_hit_r  <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_init_r  <= (in_func == FUNC_INIT);
      s1_odd_r   <= in_x[0];
      s1_gray_r  <= in_gray;
      s1_col_r   <= in_x[6:1];
      s1_row_r   <= in_y;
      s1_addr_r  <= rd_addr;
      fwd_data_r <= pix_byte;
    end
  end

  g4oled_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_shadow (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

endmodule

// ===== hdl/g4oled_back.sv =====
// Byte sequencer: queued jobs to controller bytes, one byte per cycle when not stalled.
// Depends on g4oled_pkg for the job descriptor and the start-up table.
module g4oled_back import g4oled_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_desc_t  q_desc,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_command,
  output logic       out_burst_end,
  output logic       out_last
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        byte_r;
  logic              cmd_r;
  logic              bend_r;
  logic              last_r;

  logic              load;
  logic              final_step;
  logic [7:0]        nx_byte;
  logic              nx_cmd;
  logic              nx_bend;

  always_comb begin
    final_step = q_desc.is_init ? (step_r == STEP_W'(INIT_BYTES - 1))
                                : (step_r == STEP_W'(PIXEL_BYTES - 1));
    load  = q_valid && (!out_valid_r || !out_stall);
    q_pop = load && final_step;

    if (q_desc.is_init) begin
      nx_byte = init_byte(step_r);
      nx_cmd  = 1'b1;
      nx_bend = (nx_byte == CMD_NOP);
    end else begin
      nx_cmd  = 1'b1;
      nx_bend = 1'b0;
      unique case (step_r)
        PX_COL_CMD: nx_byte = CMD_SET_COL;
        PX_COL_LO:  nx_byte = 8'(q_desc.col);
        PX_COL_HI: begin
          nx_byte = 8'(q_desc.col);
          nx_bend = 1'b1;
        end
        PX_ROW_CMD: nx_byte = CMD_SET_ROW;
        PX_ROW_LO:  nx_byte = 8'(q_desc.row);
        PX_ROW_HI: begin
          nx_byte = 8'(q_desc.row);
          nx_bend = 1'b1;
        end
        PX_DATA: begin
          nx_byte = q_desc.pix_byte;
          nx_cmd  = 1'b0;
          nx_bend = 1'b1;
        end
        default: nx_byte = CMD_NOP;
      endcase
    end

    step_nxt = step_r;
    if (load) begin
      step_nxt = final_step ? '0 : step_r + STEP_W'(1);
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end

    out_valid      = out_valid_r;
    out_byte       = byte_r;
    out_is_command = cmd_r;
    out_burst_end  = bend_r;
    out_last       = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= nx_byte;
      cmd_r  <= nx_cmd;
      bend_r <= nx_bend;
      last_r <= final_step;
    end
  end

endmodule

// ===== hdl/gray4_oled_pixel_command_writer.sv =====
// Channel  | handshake          | payload
// in       | in_valid/in_stall  | in_func, in_x, in_y, in_gray
// out      | out_valid/out_stall| out_byte, out_is_command, out_burst_end, out_last
//
// A pixel transaction yields 7 output bytes and a start-up transaction 62; the output port
// moves one byte per cycle while out_stall is low. After reset the shadow frame is cleared,
// one byte a cycle, and in_stall stays high until all FRAME_BYTES (6144) bytes are clear.
// A two-job queue lets the front end take new transactions while the output is stalled;
// in_stall rises only when that queue and the front stage are full.
// Top level: front end, job queue and byte sequencer. Depends on g4oled_pkg and the submodules.
module gray4_oled_pixel_command_writer import g4oled_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [6:0] in_x,
  input  logic [6:0] in_y,
  input  logic [3:0] in_gray,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_command,
  output logic       out_burst_end,
  output logic       out_last
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  cmd_desc_t push_desc;
  cmd_desc_t head_desc;

  g4oled_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func (in_func),
    .in_x    (in_x),
    .in_y    (in_y),
    .in_gray (in_gray),
    .q_push  (q_push),
    .q_desc  (push_desc),
    .q_full  (q_full)
  );

  g4oled_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_desc (head_desc)
  );

  g4oled_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_desc        (head_desc),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_is_command(out_is_command),
    .out_burst_end (out_burst_end),
    .out_last      (out_last)
  );

endmodule

// ===== hdl/g4oled_checker.sv =====
// Port-level checks for the grayscale OLED writer, bound to the top level.
// Depends on g4oled_pkg for the command byte codes.
module g4oled_checker import g4oled_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_is_command,
  input logic       out_burst_end,
  input logic       out_last
);

  // A stalled output transaction holds its byte and flags.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_is_command)
      && $stable(out_burst_end) && $stable(out_last))
    else $error("output transaction changed while stalled");

  // The final byte of a job always closes a chip-select burst.
  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_burst_end)
    else $error("final byte does not end a burst");

  // Display data appears only as the closing byte of a pixel job.
  a_data_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_command |-> out_last && out_burst_end)
    else $error("data byte outside the end of a pixel job");

  // A command job ends with the closing NOP of the start-up table.
  a_init_ends_nop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_is_command |-> out_byte == CMD_NOP)
    else $error("start-up sequence does not end in NOP");

endmodule

bind gray4_oled_pixel_command_writer g4oled_checker u_g4oled_checker (.*);
